/* rtl/current_sense_level_classifier_macros.svh */
// Assertion macros used by the current sense classifier checker.
`ifndef CURRENT_SENSE_LEVEL_CLASSIFIER_MACROS_SVH
`define CURRENT_SENSE_LEVEL_CLASSIFIER_MACROS_SVH

// same-cycle implication, off during reset
`define CSLC_ASSERT_HOLD(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cslc assertion failed");

// next-cycle implication, also checked around reset
`define CSLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("cslc assertion failed");

`endif

/* rtl/cslc_pkg.sv */
// Types and constants of the current sense level classifier.
package cslc_pkg;

    localparam int unsigned MEASURE_SAMPLES = 16;
    localparam int unsigned ZERO_SAMPLES    = 64;
    localparam int unsigned ADC_LOW_LIMIT   = 5;
    localparam int unsigned ADC_HIGH_LIMIT  = 1018;

    localparam int unsigned SAMPLE_W    = 10;
    localparam int unsigned SUM_W       = 18;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned CODE_W      = 16;
    localparam int unsigned MA_W        = 17;
    localparam int unsigned CUR_W       = 18;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 17;

    // burst end: count reaches samples + 1
    localparam logic [COUNT_W:0] MEAS_LAST = (COUNT_W+1)'(MEASURE_SAMPLES + 1);
    localparam logic [COUNT_W:0] ZERO_LAST = (COUNT_W+1)'(ZERO_SAMPLES + 1);

    // average = (sum * 64) / n through a reciprocal, exact for 24-bit operands
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned RECIP_W     = 33;
    localparam int unsigned SCALED_W    = SUM_W + 6;
    localparam int unsigned AVG_PROD_W  = SCALED_W + RECIP_W;
    localparam logic [63:0] RECIP_ONE   = 64'd1 << RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] MEAS_RECIP =
        RECIP_W'((RECIP_ONE + 64'(MEASURE_SAMPLES) - 64'd1) / 64'(MEASURE_SAMPLES));
    localparam logic [RECIP_W-1:0] ZERO_RECIP =
        RECIP_W'((RECIP_ONE + 64'(ZERO_SAMPLES) - 64'd1) / 64'(ZERO_SAMPLES));

    localparam logic [SUM_W-1:0] MEAS_LOW_SUM  = SUM_W'(ADC_LOW_LIMIT * MEASURE_SAMPLES);
    localparam logic [SUM_W-1:0] MEAS_HIGH_SUM = SUM_W'(ADC_HIGH_LIMIT * MEASURE_SAMPLES);
    localparam logic [SUM_W-1:0] ZERO_LOW_SUM  = SUM_W'(ADC_LOW_LIMIT * ZERO_SAMPLES);
    localparam logic [SUM_W-1:0] ZERO_HIGH_SUM = SUM_W'(ADC_HIGH_LIMIT * ZERO_SAMPLES);

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = 2;
    localparam int unsigned QUEUE_CNT_W = 3;

    localparam logic [STATUS_W-1:0] ST_VALID  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HIGH   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WARN   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ADCERR = 3'd4;

    typedef enum logic [0:0] {
        KIND_MEASURE,
        KIND_ZERO
    } t_kind;

    typedef enum logic [1:0] {
        LVL_VALID,
        LVL_HIGH,
        LVL_WARN
    } t_level;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ZERO_CODE,
        CFG_GAIN,
        CFG_MAX_ABS,
        CFG_WARN_SET,
        CFG_WARN_CLEAR,
        CFG_HIGH_SET,
        CFG_HIGH_CLEAR
    } t_cfg_index;

    typedef struct packed {
        t_kind            kind;
        logic [SUM_W-1:0] sum;
    } t_token;

    typedef struct packed {
        logic [CODE_W-1:0] zero_code;
        logic [CODE_W-1:0] gain;
        logic [MA_W-1:0]   max_abs;
        logic [MA_W-1:0]   warn_set;
        logic [MA_W-1:0]   warn_clear;
        logic [MA_W-1:0]   high_set;
        logic [MA_W-1:0]   high_clear;
    } t_cfg;

endpackage

/* rtl/cslc_front.sv */
// Front end: burst tracking and sample accumulation, emits one token per burst.
module cslc_front
    import cslc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_full,
    input  logic                i_opcode,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_push,
    output t_token              o_token
);

    t_kind              r_kind,  n_kind;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0]   r_sum,   n_sum;

    t_kind              w_kind;
    logic               w_accept;
    logic [COUNT_W-1:0] w_count;
    logic [SUM_W-1:0]   w_sum;
    logic [SUM_W-1:0]   w_add;
    logic [COUNT_W:0]   w_next;
    logic [COUNT_W:0]   w_last;

    always_comb begin
        w_kind   = t_kind'(i_opcode);
        w_accept = i_in_valid && !i_full;
        // opcode change drops the running burst
        w_count  = (w_kind != r_kind) ? '0 : r_count;
        w_sum    = (w_kind != r_kind) ? '0 : r_sum;
        w_add    = w_sum + SUM_W'(i_sample);
        w_next   = {1'b0, w_count} + 1'b1;
        w_last   = (w_kind == KIND_ZERO) ? ZERO_LAST : MEAS_LAST;

        n_kind  = r_kind;
        n_count = r_count;
        n_sum   = r_sum;
        o_push  = 1'b0;
        o_token.kind = w_kind;
        o_token.sum  = w_add;

        if (w_accept) begin
            n_kind = w_kind;
            if (w_count == '0) begin
                n_count = COUNT_W'(1);
                n_sum   = '0;
            end else if (w_next == w_last) begin
                o_push  = 1'b1;
                n_count = '0;
                n_sum   = '0;
            end else begin
                n_count = w_next[COUNT_W-1:0];
                n_sum   = w_add;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_MEASURE;
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_kind  <= n_kind;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

endmodule

/* rtl/cslc_queue.sv */
// Short token queue between front end and back end.
module cslc_queue
    import cslc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_token,
    input  logic   i_pop,
    output logic   o_valid,
    output logic   o_full,
    output t_token o_token
);

    t_token                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count,  n_count;

    logic w_push;
    logic w_pop;

    always_comb begin
        o_valid  = (r_count != '0);
        o_full   = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
        o_token  = r_mem[r_rd_ptr];
        w_push   = i_push && !o_full;
        w_pop    = i_pop && o_valid;
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QUEUE_CNT_W'(w_push) - QUEUE_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* rtl/cslc_back.sv */
// Back end: average, zero learning, current scaling and level hysteresis.
module cslc_back
    import cslc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_q_valid,
    input  t_token              i_q_token,
    output logic                o_q_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [CUR_W-1:0]    o_current_ma,
    output logic [CODE_W-1:0]   o_average_code,
    output logic [STATUS_W-1:0] o_status
);

    function automatic t_level f_next_level(t_level lvl, logic [CUR_W-1:0] amag, t_cfg cfg);
        t_level res;
        res = lvl;
        if (lvl == LVL_WARN) begin
            if (amag < {1'b0, cfg.warn_clear}) begin
                res = (amag >= {1'b0, cfg.high_set}) ? LVL_HIGH : LVL_VALID;
            end
        end else if (amag >= {1'b0, cfg.warn_set}) begin
            res = LVL_WARN;
        end else if (lvl == LVL_HIGH) begin
            if (amag < {1'b0, cfg.high_clear}) begin
                res = LVL_VALID;
            end
        end else if (amag >= {1'b0, cfg.high_set}) begin
            res = LVL_HIGH;
        end
        return res;
    endfunction

    logic w_en;

    // stage A: scaled sum times reciprocal, plausibility
    logic                  r_a_valid;
    t_kind                 r_a_kind;
    logic                  r_a_plaus;
    logic [AVG_PROD_W-1:0] r_a_prod;
    logic                  w_a_plaus;
    logic [AVG_PROD_W-1:0] w_a_prod;
    logic [RECIP_W-1:0]    w_recip;
    logic [SUM_W-1:0]      w_low;
    logic [SUM_W-1:0]      w_high;

    // stage B: offset times gain
    logic                    r_b_valid;
    logic                    r_b_plaus;
    logic [CODE_W-1:0]       r_b_avg;
    logic signed [2*MA_W-1:0] r_b_prod;
    logic [CODE_W-1:0]       w_a_avg;
    logic [CODE_W-1:0]       w_zero;
    logic signed [MA_W-1:0]  w_diff;
    logic signed [2*MA_W-1:0] w_prod;
    logic [CODE_W-1:0]       r_learned_zero;
    logic                    r_zero_learned;

    // stage C: rounding, saturation, classification
    logic                  r_c_valid;
    logic [CUR_W-1:0]      r_c_current;
    logic [CODE_W-1:0]     r_c_avg;
    logic [STATUS_W-1:0]   r_c_status;
    t_level                r_level;
    logic                  w_neg;
    logic [2*MA_W-1:0]     w_abs;
    logic [2*MA_W-1:0]     w_rnd;
    logic [2*MA_W-15:0]    w_mag;
    logic [CUR_W-1:0]      w_amag;
    logic [CUR_W-1:0]      w_cur;
    logic                  w_range;
    t_level                w_level;
    logic [CUR_W-1:0]      w_c_current;
    logic [STATUS_W-1:0]   w_c_status;
    logic                  w_lvl_upd;

    always_comb begin
        w_en    = !r_c_valid || !i_out_stall;
        o_q_pop = w_en && i_q_valid;

        w_recip  = (i_q_token.kind == KIND_ZERO) ? ZERO_RECIP : MEAS_RECIP;
        w_low    = (i_q_token.kind == KIND_ZERO) ? ZERO_LOW_SUM : MEAS_LOW_SUM;
        w_high   = (i_q_token.kind == KIND_ZERO) ? ZERO_HIGH_SUM : MEAS_HIGH_SUM;
        w_a_prod = AVG_PROD_W'({i_q_token.sum, 6'b0}) * AVG_PROD_W'(w_recip);
        w_a_plaus = !((i_q_token.sum < w_low) || (i_q_token.sum > w_high));

        w_a_avg = r_a_prod[RECIP_SHIFT +: CODE_W];
        w_zero  = r_zero_learned ? r_learned_zero : i_cfg.zero_code;
        w_diff  = $signed({1'b0, w_a_avg}) - $signed({1'b0, w_zero});
        w_prod  = (2*MA_W)'(w_diff) * (2*MA_W)'($signed({1'b0, i_cfg.gain}));

        w_neg = r_b_prod[2*MA_W-1];
        w_abs = w_neg ? (2*MA_W)'(-r_b_prod) : (2*MA_W)'(r_b_prod);
        w_rnd = w_abs + (2*MA_W)'(8192);
        w_mag = w_rnd[2*MA_W-1:14];
        if (w_neg) begin
            w_amag = (w_mag > (2*MA_W-14)'(131072)) ? CUR_W'(131072) : w_mag[CUR_W-1:0];
        end else begin
            w_amag = (w_mag > (2*MA_W-14)'(131071)) ? CUR_W'(131071) : w_mag[CUR_W-1:0];
        end
        w_cur   = w_neg ? (~w_amag + 1'b1) : w_amag;
        w_range = (w_amag > {1'b0, i_cfg.max_abs});
        w_level = f_next_level(r_level, w_amag, i_cfg);

        w_lvl_upd = 1'b0;
        if (!r_b_plaus) begin
            w_c_current = '0;
            w_c_status  = ST_ADCERR;
        end else if (w_range) begin
            w_c_current = w_cur;
            w_c_status  = ST_RANGE;
        end else begin
            w_c_current = w_cur;
            w_c_status  = {1'b0, w_level};
            w_lvl_upd   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_kind    <= i_q_token.kind;
            r_a_plaus   <= w_a_plaus;
            r_a_prod    <= w_a_prod;
            r_b_plaus   <= r_a_plaus;
            r_b_avg     <= w_a_avg;
            r_b_prod    <= w_prod;
            r_c_current <= w_c_current;
            r_c_avg     <= r_b_avg;
            r_c_status  <= w_c_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid      <= 1'b0;
            r_b_valid      <= 1'b0;
            r_c_valid      <= 1'b0;
            r_learned_zero <= '0;
            r_zero_learned <= 1'b0;
            r_level        <= LVL_VALID;
        end else if (w_en) begin
            r_a_valid <= i_q_valid;
            r_b_valid <= r_a_valid && (r_a_kind == KIND_MEASURE);
            r_c_valid <= r_b_valid;
            if (r_a_valid && (r_a_kind == KIND_ZERO) && r_a_plaus) begin
                r_learned_zero <= w_a_avg;
                r_zero_learned <= 1'b1;
            end
            if (r_b_valid && w_lvl_upd) begin
                r_level <= w_level;
            end
        end
    end

    assign o_out_valid    = r_c_valid;
    assign o_current_ma   = r_c_current;
    assign o_average_code = r_c_avg;
    assign o_status       = r_c_status;

endmodule

/* rtl/current_sense_level_classifier.sv */
// Top level of the current sense level classifier: config registers and datapath.
//
// Input channel: i_in_valid / o_in_stall carry one ADC sample (i_sample) and its
// burst kind (i_opcode, 0 measure, 1 zero calibration) per transfer. A change of
// opcode starts a new burst; the first sample of a burst is discarded.
// Output channel: o_out_valid / i_out_stall carry one result per measure burst:
// o_current_ma, o_average_code and o_status. Zero bursts give no result.
// Throughput: one sample per cycle while the token queue is not full. The front end needs one add per sample; the
// back end pipeline (reciprocal multiply, gain multiply, classify) takes a burst.
// The token of a burst's last sample passes the queue and back end stages A, B
// and C before the result is valid. A 4-entry token queue separates the two
// halves; a stalled output holds its result and the pipeline behind it, and
// the input stalls only once the queue fills.
// Reset (synchronous, active low) restores register defaults, clears the
// running burst, the learned zero and the load level, and empties the pipeline.
// Config writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at the next edge;
// indexes beyond the last register are ignored.
module current_sense_level_classifier
    import cslc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_opcode,
    input  logic [SAMPLE_W-1:0]    i_sample,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [CUR_W-1:0]       o_current_ma,
    output logic [CODE_W-1:0]      o_average_code,
    output logic [STATUS_W-1:0]    o_status
);

    t_cfg   r_cfg;
    logic   w_push;
    t_token w_push_token;
    logic   w_q_valid;
    logic   w_q_full;
    t_token w_q_token;
    logic   w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_code  <= CODE_W'(32768);
            r_cfg.gain       <= CODE_W'(6758);
            r_cfg.max_abs    <= MA_W'(5000);
            r_cfg.warn_set   <= MA_W'(4500);
            r_cfg.warn_clear <= MA_W'(4000);
            r_cfg.high_set   <= MA_W'(3000);
            r_cfg.high_clear <= MA_W'(2500);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ZERO_CODE:  r_cfg.zero_code  <= i_cfg_data[CODE_W-1:0];
                CFG_GAIN:       r_cfg.gain       <= i_cfg_data[CODE_W-1:0];
                CFG_MAX_ABS:    r_cfg.max_abs    <= i_cfg_data[MA_W-1:0];
                CFG_WARN_SET:   r_cfg.warn_set   <= i_cfg_data[MA_W-1:0];
                CFG_WARN_CLEAR: r_cfg.warn_clear <= i_cfg_data[MA_W-1:0];
                CFG_HIGH_SET:   r_cfg.high_set   <= i_cfg_data[MA_W-1:0];
                CFG_HIGH_CLEAR: r_cfg.high_clear <= i_cfg_data[MA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = w_q_full;

    cslc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_full     (w_q_full),
        .i_opcode   (i_opcode),
        .i_sample   (i_sample),
        .o_push     (w_push),
        .o_token    (w_push_token)
    );

    cslc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_token (w_push_token),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_token (w_q_token)
    );

    cslc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (w_q_valid),
        .i_q_token      (w_q_token),
        .o_q_pop        (w_q_pop),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_current_ma   (o_current_ma),
        .o_average_code (o_average_code),
        .o_status       (o_status)
    );

endmodule

/* rtl/cslc_checker.sv */
// Port-level checker for the current sense level classifier, bound to the top.
`include "current_sense_level_classifier_macros.svh"

module cslc_checker
    import cslc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [CUR_W-1:0]    o_current_ma,
    input logic [CODE_W-1:0]   o_average_code,
    input logic [STATUS_W-1:0] o_status
);

    `CSLC_ASSERT_NEXT(a_reset_no_result, !i_rst_n, !o_out_valid)
    `CSLC_ASSERT_NEXT(a_stall_holds, i_rst_n && o_out_valid && i_out_stall, o_out_valid && $stable(o_current_ma) && $stable(o_average_code) && $stable(o_status))
    `CSLC_ASSERT_HOLD(a_status_code, o_out_valid, o_status <= ST_ADCERR)
    `CSLC_ASSERT_HOLD(a_adc_err_zero, o_out_valid && (o_status == ST_ADCERR), o_current_ma == '0)

endmodule

bind current_sense_level_classifier cslc_checker u_cslc_checker (.*);
